FILE: src/unique_key_fifo_defines.svh
// Assertion macros for the unique key FIFO top level.
`ifndef UNIQUE_KEY_FIFO_DEFINES_SVH
`define UNIQUE_KEY_FIFO_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UKF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define UKF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ukf_pkg.sv
// Package with the types and constants of the unique key FIFO.
package ukf_pkg;

    localparam int UKF_DEPTH = 16;
    localparam int UKF_DATA_W = 32;
    localparam int UKF_OCC_W = 5;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DEQUEUED  = 3'd3,
        ST_EMPTY     = 3'd4
    } ukf_status_t;

    typedef enum logic {
        REQ_ENQUEUE = 1'b0,
        REQ_DEQUEUE = 1'b1
    } ukf_req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ,
        S_RESULT
    } ukf_state_t;

    typedef struct packed {
        logic                  we;
        logic [UKF_DATA_W-1:0] key;
        logic [UKF_DATA_W-1:0] value;
    } ukf_wr_t;

endpackage

FILE: src/unique_key_fifo.sv
// Top level of the unique key FIFO: a queue of key and value pairs without duplicate keys.
//
// The input channel carries one request per transfer: an enqueue of a key and value pair,
// or a dequeue. The output channel returns exactly one result per request with a status,
// the dequeued pair (zero unless dequeued), the occupancy afterwards and an empty flag.
// An enqueue walks the held keys one per cycle through a single comparator, reading the
// key memory at one address each cycle; a match ends the walk early.
// A dequeue goes through S_DEQ, while the registered memory read of the head entry runs, and then S_RESULT.
// The result appears on the output in the same cycle as the block is ready for the next request.
// Only one request is in work at a time; stall stays high until its result is loaded.
// The result register lets a new request start while an earlier result still waits.
// When the receiver stalls, the result holds and a finished request waits in its final
// step until the result register is free.
// Reset clears the pointers, the count and the valid flags; the queue is empty afterwards,
// and the memories keep no defined contents until written.
`include "unique_key_fifo_defines.svh"

module unique_key_fifo
    import ukf_pkg::*;
#(
    parameter int DEPTH = UKF_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [UKF_DATA_W-1:0] entry_key,
    input  logic [UKF_DATA_W-1:0] entry_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [UKF_DATA_W-1:0] out_key,
    output logic [UKF_DATA_W-1:0] out_value,
    output logic [UKF_OCC_W-1:0]  occupancy,
    output logic                  is_empty
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    ukf_wr_t               wr;
    logic [UKF_DATA_W-1:0] rd_key;
    logic [UKF_DATA_W-1:0] rd_value;
    logic                  pair_zero;
    logic                  queue_empty;

    ukf_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr       (wr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    ukf_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr          (wr),
        .rd_key      (rd_key),
        .rd_value    (rd_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_key     (out_key),
        .out_value   (out_value),
        .occupancy   (occupancy),
        .is_empty    (is_empty)
    );

    assign pair_zero   = (out_key == '0) && (out_value == '0);
    assign queue_empty = is_empty && (occupancy == '0);

    `UKF_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "not busy")
    `UKF_ASSERT_SAME(a_zero_pair, out_valid && (status != ST_DEQUEUED), pair_zero, "nonzero pair")
    `UKF_ASSERT_SAME(a_empty_flag, out_valid && (status == ST_EMPTY), queue_empty, "empty status")
    `UKF_ASSERT_SAME(a_full_not_empty, out_valid && (status == ST_FULL), !is_empty, "full status")

endmodule

FILE: src/ukf_store.sv
// Key and value memory with one write port and one registered read port.
module ukf_store
    import ukf_pkg::*;
#(
    parameter int DEPTH = UKF_DEPTH,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      rd_addr,
    input  logic [IDX_W-1:0]      wr_addr,
    input  ukf_wr_t               wr,
    output logic [UKF_DATA_W-1:0] rd_key,
    output logic [UKF_DATA_W-1:0] rd_value
);

    logic [UKF_DATA_W-1:0] key_mem [DEPTH];
    logic [UKF_DATA_W-1:0] value_mem [DEPTH];
    logic [UKF_DATA_W-1:0] rd_key_reg;
    logic [UKF_DATA_W-1:0] rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            key_mem[wr_addr]   <= wr.key;
            value_mem[wr_addr] <= wr.value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

FILE: src/ukf_seq.sv
// Sequencer with ring pointers, the shared key comparator and the result register.
module ukf_seq
    import ukf_pkg::*;
#(
    parameter int DEPTH = UKF_DEPTH,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [UKF_DATA_W-1:0] entry_key,
    input  logic [UKF_DATA_W-1:0] entry_value,
    output logic [IDX_W-1:0]      rd_addr,
    output logic [IDX_W-1:0]      wr_addr,
    output ukf_wr_t               wr,
    input  logic [UKF_DATA_W-1:0] rd_key,
    input  logic [UKF_DATA_W-1:0] rd_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [UKF_DATA_W-1:0] out_key,
    output logic [UKF_DATA_W-1:0] out_value,
    output logic [UKF_OCC_W-1:0]  occupancy,
    output logic                  is_empty
);

    ukf_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]      issued_reg, issued_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [UKF_DATA_W-1:0] key_reg, key_next;
    logic [UKF_DATA_W-1:0] value_reg, value_next;
    ukf_status_t           status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    ukf_status_t           out_status_reg, out_status_next;
    logic [UKF_DATA_W-1:0] out_key_reg, out_key_next;
    logic [UKF_DATA_W-1:0] out_value_reg, out_value_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  is_empty_reg, is_empty_next;

    logic match;
    logic scan_done;
    logic out_free;

    assign match     = cmp_valid_reg && (rd_key == key_reg);
    assign scan_done = (issued_reg == count_reg) && !cmp_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == REQ_DEQUEUE) ? S_DEQ : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match || scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_DEQ:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_ptr_next   = scan_ptr_reg;
        issued_next     = issued_reg;
        cmp_valid_next  = cmp_valid_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        is_empty_next   = is_empty_reg;
        wr.we           = 1'b0;
        wr.key          = key_reg;
        wr.value        = value_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next       = entry_key;
                    value_next     = entry_value;
                    scan_ptr_next  = head_reg;
                    issued_next    = '0;
                    cmp_valid_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (issued_reg < count_reg)
                begin
                    scan_ptr_next  = (scan_ptr_reg == IDX_W'(DEPTH - 1)) ? '0
                                     : scan_ptr_reg + 1'b1;
                    issued_next    = issued_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                if (match)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (scan_done)
                begin
                    status_next = (count_reg == CNT_W'(DEPTH)) ? ST_FULL : ST_ENQUEUED;
                end
            end
            S_DEQ:
            begin
                status_next = (count_reg == '0) ? ST_EMPTY : ST_DEQUEUED;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_key_next    = '0;
                    out_value_next  = '0;
                    case (status_reg)
                        ST_ENQUEUED:
                        begin
                            wr.we      = 1'b1;
                            tail_next  = (tail_reg == IDX_W'(DEPTH - 1)) ? '0
                                         : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        ST_DEQUEUED:
                        begin
                            out_key_next   = rd_key;
                            out_value_next = rd_value;
                            head_next      = (head_reg == IDX_W'(DEPTH - 1)) ? '0
                                             : head_reg + 1'b1;
                            count_next     = count_reg - 1'b1;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    out_count_next = count_next;
                    is_empty_next  = (count_next == '0);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            issued_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            issued_reg    <= issued_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg   <= scan_ptr_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        is_empty_reg   <= is_empty_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign rd_addr   = (state_reg == S_SCAN) ? scan_ptr_reg : head_reg;
    assign wr_addr   = tail_reg;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_key   = out_key_reg;
    assign out_value = out_value_reg;
    assign occupancy = UKF_OCC_W'(out_count_reg);
    assign is_empty  = is_empty_reg;

endmodule
